FILE: rtl/core/rbd_pkg.sv
// rbd_pkg: shared types and constants of the ring buffer deque.
// Request codes, field widths, controller command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

    // Field widths of the request and response words
    localparam int FUNC_W  = 3;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;
    localparam int CAP_W   = 4;

    // Default sizing handed to the top level
    localparam int RBD_DEPTH      = 16;
    localparam int RBD_DATA_WIDTH = 32;

    // Capacity value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

    // Operation the datapath carries out in the execute cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_CLEAR
    } dq_op_t;

    // Controller to datapath
    typedef struct packed {
        logic   capture;   // latch the accepted request word
        dq_op_t op;        // operation to apply this cycle
        logic   refused;   // request turned away (full / empty)
        logic   load_out;  // load the response register
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
    } dq_stat_t;

endpackage

FILE: rtl/core/rbd_req_if.sv
// rbd_req_if: request channel of the ring buffer deque (valid/ready).
// Depends on rbd_pkg for field widths.
`timescale 1ns / 1ps

interface rbd_req_if;
    import rbd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);

endinterface

FILE: rtl/core/rbd_rsp_if.sv
// rbd_rsp_if: response channel of the ring buffer deque (valid/ready).
// Depends on rbd_pkg for field widths.
`timescale 1ns / 1ps

interface rbd_rsp_if;
    import rbd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic signed [WORD_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output status, output data_out, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input data_out, input count,
                    input is_empty, input is_full, output ready);

endinterface

FILE: rtl/core/rbd_ctrl.sv
// rbd_ctrl: sequencing state machine of the ring buffer deque.
// Decodes the request against empty/full and drives the datapath commands.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rbd_pkg::dq_stat_t stat,
    output rbd_pkg::dq_cmd_t  cmd
);
    import rbd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.op         = OP_NONE;
        cmd.refused    = 1'b0;
        cmd.load_out   = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.func)
                    FUNC_PUSH_BACK:
                    begin
                        cmd.refused = stat.full;
                        cmd.op      = stat.full ? OP_NONE : OP_PUSH_BACK;
                    end
                    FUNC_PUSH_FRONT:
                    begin
                        cmd.refused = stat.full;
                        cmd.op      = stat.full ? OP_NONE : OP_PUSH_FRONT;
                    end
                    FUNC_POP_BACK:
                    begin
                        cmd.refused = stat.empty;
                        cmd.op      = stat.empty ? OP_NONE : OP_POP_BACK;
                    end
                    FUNC_POP_FRONT:
                    begin
                        cmd.refused = stat.empty;
                        cmd.op      = stat.empty ? OP_NONE : OP_POP_FRONT;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.op = OP_CLEAR;
                    end
                    default:
                    begin
                        cmd.op = OP_NONE;
                    end
                endcase
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the response register to drain
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted request always goes to execute next
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execute");

    // A response held up by the sink keeps the controller in finish
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == S_FINISH))
        else $error("response register overwritten while stalled");

    // The response register is loaded only once the previous word is gone
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("response loaded while previous word pending");

endmodule

FILE: rtl/core/rbd_dpath.sv
// rbd_dpath: pointers, slot memory, capacity register and response register
// of the ring buffer deque. Driven by rbd_ctrl commands. Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_dpath #(
    parameter int DEPTH      = rbd_pkg::RBD_DEPTH,
    parameter int DATA_WIDTH = rbd_pkg::RBD_DATA_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbd_pkg::CAP_W-1:0]         cfg_wdata,
    input  logic [rbd_pkg::FUNC_W-1:0]        func,
    input  logic signed [rbd_pkg::WORD_W-1:0] data_in,
    input  rbd_pkg::dq_cmd_t                  cmd,
    output rbd_pkg::dq_stat_t                 stat,
    output logic                              status,
    output logic signed [rbd_pkg::WORD_W-1:0] data_out,
    output logic [rbd_pkg::COUNT_W-1:0]       count,
    output logic                              is_empty,
    output logic                              is_full
);
    import rbd_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int CAP_LIM = (DEPTH - 1 < 15) ? DEPTH - 1 : 15;

    logic [CAP_W-1:0]      capacity_reg;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      back_reg, back_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [WORD_W-1:0]     data_reg;
    logic [DATA_WIDTH-1:0] slots [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  pop_ok_reg;
    logic                  refused_reg;

    logic [PTR_W-1:0]      last_ptr;
    logic [PTR_W-1:0]      back_inc, back_dec, front_inc, front_dec;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    logic                  wr_en, rd_en;
    logic [CNT_W-1:0]      cnt;

    logic                  status_reg;
    logic [WORD_W-1:0]     data_out_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  empty_reg, full_reg;

    // Highest slot index of the ring (capacity clamped to 1..min(DEPTH-1, 15))
    always_comb
    begin
        if (capacity_reg == '0)
            last_ptr = PTR_W'(1);
        else if (int'(capacity_reg) > CAP_LIM)
            last_ptr = PTR_W'(CAP_LIM);
        else
            last_ptr = PTR_W'(capacity_reg);
    end

    // Wrapping neighbours of each pointer
    assign back_inc  = (back_reg == last_ptr) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? last_ptr : back_reg - 1'b1;
    assign front_inc = (front_reg == last_ptr) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? last_ptr : front_reg - 1'b1;

    assign stat.func  = func_reg;
    assign stat.empty = (front_reg == back_reg);
    assign stat.full  = (back_inc == front_reg);

    // Pointer update and slot access per operation
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = back_reg;
        rd_addr    = front_reg;
        case (cmd.op)
            OP_PUSH_BACK:
            begin
                wr_en     = 1'b1;
                wr_addr   = back_reg;
                back_next = back_inc;
            end
            OP_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
            end
            OP_POP_BACK:
            begin
                rd_en     = 1'b1;
                rd_addr   = back_dec;
                back_next = back_dec;
            end
            OP_POP_FRONT:
            begin
                rd_en      = 1'b1;
                rd_addr    = front_reg;
                front_next = front_inc;
            end
            OP_CLEAR:
            begin
                front_next = '0;
                back_next  = '0;
            end
            default:
            begin
                front_next = front_reg;
            end
        endcase
    end

    // Items held: (back - front) mod ring size
    always_comb
    begin
        if (back_reg >= front_reg)
            cnt = {1'b0, back_reg} - {1'b0, front_reg};
        else
            cnt = {1'b0, back_reg} + {1'b0, last_ptr} + 1'b1 - {1'b0, front_reg};
    end

    // Capacity register and pointers; a capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            front_reg    <= '0;
            back_reg     <= '0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
            front_reg    <= '0;
            back_reg     <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

    // Request word and execute results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            data_reg <= $unsigned(data_in);
        end
        if (cmd.op != OP_NONE || cmd.refused)
        begin
            pop_ok_reg  <= (cmd.op == OP_POP_BACK) || (cmd.op == OP_POP_FRONT);
            refused_reg <= cmd.refused;
        end
        else if (cmd.capture)
        begin
            pop_ok_reg  <= 1'b0;
            refused_reg <= 1'b0;
        end
    end

    // Slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_addr] <= DATA_WIDTH'(data_reg);
        if (rd_en)
            rd_data_reg <= slots[rd_addr];
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg   <= refused_reg;
            data_out_reg <= pop_ok_reg ? WORD_W'(rd_data_reg) : '0;
            count_reg    <= COUNT_W'(cnt);
            empty_reg    <= (cnt == '0);
            full_reg     <= (cnt == {1'b0, last_ptr});
        end
    end

    assign status   = status_reg;
    assign data_out = $signed(data_out_reg);
    assign count    = count_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

    // Pointers stay inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg <= last_ptr) && (back_reg <= last_ptr))
        else $error("pointer outside the ring");

    // A refused push means full, a refused pop means empty
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.refused |-> (stat.full || stat.empty))
        else $error("request refused with room and data available");

    // A capacity write leaves an empty deque
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (front_reg == '0) && (back_reg == '0))
        else $error("capacity write did not empty the deque");

endmodule

FILE: rtl/core/ring_buffer_deque.sv
// ring_buffer_deque: top level of the double-ended queue in a slot ring.
// Joins rbd_ctrl and rbd_dpath; channels are rbd_req_if and rbd_rsp_if.
// Depends on rbd_pkg.
//
//   channel   dir   handshake        word
//   req       in    valid / ready    func, data_in
//   rsp       out   valid / ready    status, data_out, count, is_empty, is_full
//   cfg       in    cfg_we           cfg_wdata (capacity)
//
// Each request passes through accept, execute (one slot access and one
// pointer step, slot read registered), load of the response register.
// A new request is accepted while the previous response still waits; the
// controller holds in its final cycle until the response register is free.
// Reset (rst_n low, asynchronous) empties the deque and sets capacity to 15.
// Slot contents are not cleared; only slots filled by a push are ever read.
`timescale 1ns / 1ps

module ring_buffer_deque #(
    parameter int DEPTH      = rbd_pkg::RBD_DEPTH,
    parameter int DATA_WIDTH = rbd_pkg::RBD_DATA_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rbd_req_if.sink                   req,
    rbd_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [rbd_pkg::CAP_W-1:0] cfg_wdata
);
    import rbd_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rbd_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .func      (req.func),
        .data_in   (req.data_in),
        .cmd       (cmd),
        .stat      (stat),
        .status    (rsp.status),
        .data_out  (rsp.data_out),
        .count     (rsp.count),
        .is_empty  (rsp.is_empty),
        .is_full   (rsp.is_full)
    );

endmodule
